### rtl/bitmap_page_allocator_top_defines.svh
// Assertion macros for the bitmap page allocator.
// Used by modules that check their own control logic; needs i_clk and i_rst_n in scope.
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bpa_pkg.sv
// Shared constants, codes, types and helper functions of the bitmap page allocator.
// No dependencies; imported by every module of the block.
package bpa_pkg;

    localparam int NUM_WORDS  = 1024;
    localparam int PAGE_SHIFT = 12;

    localparam int KIND_W   = 3;
    localparam int ADDR_W   = 27;
    localparam int BYTES_W  = 28;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 16;
    localparam int DATA_W   = 32;
    localparam int BIT_W    = $clog2(DATA_W);
    localparam int WORD_W   = $clog2(NUM_WORDS);
    localparam int PIDX_W   = ADDR_W - PAGE_SHIFT;
    localparam int NPG_W    = BYTES_W + 1 - PAGE_SHIFT;
    localparam int EXT_W    = NPG_W + 1;

    localparam longint TOTAL_PAGES = longint'(NUM_WORDS) * DATA_W;
    localparam longint EXT_MAX     = (longint'(1) << EXT_W) - 1;

    localparam logic [COUNT_W-1:0] USED_MAX =
        COUNT_W'((TOTAL_PAGES > 65535) ? 65535 : TOTAL_PAGES);
    localparam logic [EXT_W-1:0] PAGE_CAP =
        EXT_W'((TOTAL_PAGES > EXT_MAX) ? EXT_MAX : TOTAL_PAGES);
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(NUM_WORDS - 1);
    localparam logic [BYTES_W:0] PAGE_MASK = (BYTES_W+1)'((1 << PAGE_SHIFT) - 1);
    localparam logic [DATA_W-1:0] FULL_WORD = '1;

    localparam logic [KIND_W-1:0] KIND_INIT      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FREE_PAGE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FREE_RGN  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RST_COUNT = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PAGE0 = 2'd2;

    typedef struct packed {
        logic              we;
        logic [WORD_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [WORD_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [BIT_W-1:0] low_zero(input logic [DATA_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int b = DATA_W - 1; b >= 0; b--) begin
            if (!v[b]) begin
                idx = BIT_W'(b);
            end
        end
        return idx;
    endfunction

    function automatic logic [DATA_W-1:0] span_mask(input logic [BIT_W-1:0] lo,
                                                    input logic [BIT_W-1:0] hi);
        logic [BIT_W-1:0] top_gap;
        top_gap = BIT_W'(DATA_W - 1) - hi;
        return (FULL_WORD << lo) & (FULL_WORD >> top_gap);
    endfunction

endpackage

### rtl/bitmap_page_allocator_top.sv
// Bitmap page allocator. How long an item takes depends on its kind: a free of page zero, a count
// reset and an unused kind go straight to the result; a page free reads and rewrites one map word;
// an allocation scans map words until it hits a free bit or runs out of memory; a region free reads
// and rewrites each map word that it touches; initialize refills every map word. The next item is
// taken in the cycle after the result moves to the output register; the one-word-per-cycle map RAM
// port sets the rate. After reset the map is filled with ones, word by word, before the first item.
module bitmap_page_allocator_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [bpa_pkg::KIND_W-1:0]     i_kind,
    input  logic [bpa_pkg::ADDR_W-1:0]     i_phys_address,
    input  logic [bpa_pkg::BYTES_W-1:0]    i_region_bytes,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bpa_pkg::ADDR_W-1:0]     o_page_address,
    output logic [bpa_pkg::STATUS_W-1:0]   o_status,
    output logic [bpa_pkg::COUNT_W-1:0]    o_pages_used
);
    import bpa_pkg::*;

    t_ram_req             ram_req;
    logic [DATA_W-1:0]    ram_rdata;
    logic                 ctrl_ready;
    logic                 res_valid;
    logic                 res_take;
    logic                 start;
    logic [ADDR_W-1:0]    res_addr;
    logic [STATUS_W-1:0]  res_status;
    logic [COUNT_W-1:0]   res_used;

    logic                 r_out_valid;
    logic [ADDR_W-1:0]    r_page_address;
    logic [STATUS_W-1:0]  r_status;
    logic [COUNT_W-1:0]   r_pages_used;

    assign start    = i_in_valid && ctrl_ready;
    assign res_take = res_valid && (!r_out_valid || i_out_ready);

    bpa_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_kind         (i_kind),
        .i_phys_address (i_phys_address),
        .i_region_bytes (i_region_bytes),
        .o_ready        (ctrl_ready),
        .o_res_valid    (res_valid),
        .i_res_take     (res_take),
        .o_page_address (res_addr),
        .o_status       (res_status),
        .o_pages_used   (res_used),
        .o_ram_req      (ram_req),
        .i_rdata        (ram_rdata)
    );

    bpa_map_ram u_map_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_take) begin
            r_page_address <= res_addr;
            r_status       <= res_status;
            r_pages_used   <= res_used;
        end
    end

    assign o_in_ready     = ctrl_ready;
    assign o_out_valid    = r_out_valid;
    assign o_page_address = r_page_address;
    assign o_status       = r_status;
    assign o_pages_used   = r_pages_used;

endmodule

### rtl/bpa_map_ram.sv
// Page bitmap storage: one write port and one registered read port.
// Depends on bpa_pkg for the depth, word width and request type.
module bpa_map_ram (
    input  logic                         i_clk,
    input  bpa_pkg::t_ram_req            i_req,
    output logic [bpa_pkg::DATA_W-1:0]   o_rdata
);
    import bpa_pkg::*;

    logic [DATA_W-1:0] mem [NUM_WORDS];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bpa_ctrl.sv
// Operation sequencer: scans, clears and fills the bitmap through the map RAM.
// Depends on bpa_pkg and on the assertion macros header.
`include "bitmap_page_allocator_top_defines.svh"

module bpa_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [bpa_pkg::KIND_W-1:0]     i_kind,
    input  logic [bpa_pkg::ADDR_W-1:0]     i_phys_address,
    input  logic [bpa_pkg::BYTES_W-1:0]    i_region_bytes,
    output logic                           o_ready,
    output logic                           o_res_valid,
    input  logic                           i_res_take,
    output logic [bpa_pkg::ADDR_W-1:0]     o_page_address,
    output logic [bpa_pkg::STATUS_W-1:0]   o_status,
    output logic [bpa_pkg::COUNT_W-1:0]    o_pages_used,
    output bpa_pkg::t_ram_req              o_ram_req,
    input  logic [bpa_pkg::DATA_W-1:0]     i_rdata
);
    import bpa_pkg::*;

    typedef enum logic [3:0] {
        S_FILL, S_IDLE, S_SCAN, S_WRITE, S_FREE_RD, S_FREE_WR,
        S_RGN_END, S_RGN_CNT, S_WALK, S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_used, n_used;
    logic [WORD_W-1:0]    r_hint, n_hint;
    logic [WORD_W-1:0]    r_word, n_word;
    logic [WORD_W-1:0]    r_cnt, n_cnt;
    logic                 r_rvalid, n_rvalid;
    logic [WORD_W-1:0]    r_raddr_q, n_raddr_q;
    logic                 r_iss, n_iss;
    logic                 r_fill_init, n_fill_init;
    logic [KIND_W-1:0]    r_kind, n_kind;
    logic [WORD_W-1:0]    r_wr_addr, n_wr_addr;
    logic [DATA_W-1:0]    r_wr_data, n_wr_data;
    logic [BIT_W-1:0]     r_fbit, n_fbit;
    logic [EXT_W-1:0]     r_pstart, n_pstart;
    logic [NPG_W-1:0]     r_npg, n_npg;
    logic [EXT_W-1:0]     r_rg_end, n_rg_end;
    logic [WORD_W-1:0]    r_first, n_first;
    logic [WORD_W-1:0]    r_last, n_last;
    logic [BIT_W-1:0]     r_lo, n_lo;
    logic [BIT_W-1:0]     r_hi, n_hi;
    logic [ADDR_W-1:0]    r_res_addr, n_res_addr;
    logic [STATUS_W-1:0]  r_res_status, n_res_status;

    t_ram_req             ram_req;
    logic [PIDX_W-1:0]    in_page;
    logic [EXT_W-1:0]     in_page_ext;
    logic [BYTES_W:0]     bytes_up;
    logic [WORD_W-1:0]    hint_norm;
    logic [BIT_W-1:0]     zero_bit;
    logic [WORD_W+BIT_W+PAGE_SHIFT-1:0] found_addr;
    logic [EXT_W-1:0]     rg_sum;
    logic [EXT_W-1:0]     rg_k;
    logic [EXT_W-1:0]     rg_last_pg;
    logic [EXT_W-1:0]     used_ext;
    logic [BIT_W-1:0]     walk_lo;
    logic [BIT_W-1:0]     walk_hi;

    always_comb begin
        in_page     = i_phys_address[ADDR_W-1:PAGE_SHIFT];
        in_page_ext = EXT_W'(in_page);
        bytes_up    = {1'b0, i_region_bytes} + PAGE_MASK;
        hint_norm   = (r_hint == '0 || {1'b0, r_hint} >= (WORD_W+1)'(NUM_WORDS))
                      ? WORD_W'(1) : r_hint;
        zero_bit    = low_zero(i_rdata);
        found_addr  = {r_raddr_q, zero_bit, {PAGE_SHIFT{1'b0}}};
        rg_sum      = r_pstart + EXT_W'(r_npg);
        rg_k        = r_rg_end - r_pstart;
        rg_last_pg  = r_rg_end - EXT_W'(1);
        used_ext    = EXT_W'(r_used);
        walk_lo     = (r_raddr_q == r_first) ? r_lo : '0;
        walk_hi     = (r_raddr_q == r_last) ? r_hi : BIT_W'(DATA_W - 1);
    end

    always_comb begin
        ram_req       = '0;
        ram_req.raddr = r_word;
        ram_req.waddr = r_wr_addr;
        ram_req.wdata = r_wr_data;
        case (r_state)
            S_FILL: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_word;
                ram_req.wdata = FULL_WORD;
            end
            S_SCAN: begin
                ram_req.re = (r_cnt != LAST_WORD);
            end
            S_WRITE: begin
                ram_req.we = 1'b1;
            end
            S_FREE_RD: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = r_wr_addr;
            end
            S_FREE_WR: begin
                ram_req.we    = 1'b1;
                ram_req.wdata = i_rdata & ~(DATA_W'(1) << r_fbit);
            end
            S_WALK: begin
                ram_req.re    = r_iss;
                ram_req.we    = r_rvalid;
                ram_req.waddr = r_raddr_q;
                ram_req.wdata = i_rdata & ~span_mask(walk_lo, walk_hi);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_hint       = r_hint;
        n_word       = r_word;
        n_cnt        = r_cnt;
        n_rvalid     = ram_req.re;
        n_raddr_q    = ram_req.raddr;
        n_iss        = r_iss;
        n_fill_init  = r_fill_init;
        n_kind       = r_kind;
        n_wr_addr    = r_wr_addr;
        n_wr_data    = r_wr_data;
        n_fbit       = r_fbit;
        n_pstart     = r_pstart;
        n_npg        = r_npg;
        n_rg_end     = r_rg_end;
        n_first      = r_first;
        n_last       = r_last;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        case (r_state)
            S_FILL: begin
                n_word = r_word + WORD_W'(1);
                if (r_word == LAST_WORD) begin
                    if (r_fill_init) begin
                        n_used  = USED_MAX;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_kind       = i_kind;
                    n_res_addr   = '0;
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                    case (i_kind)
                        KIND_INIT: begin
                            n_word      = '0;
                            n_fill_init = 1'b1;
                            n_state     = S_FILL;
                        end
                        KIND_ALLOC: begin
                            n_hint  = hint_norm;
                            n_word  = hint_norm;
                            n_cnt   = '0;
                            n_state = S_SCAN;
                        end
                        KIND_FREE_PAGE: begin
                            n_wr_addr = WORD_W'(in_page >> BIT_W);
                            n_fbit    = in_page[BIT_W-1:0];
                            if (in_page == '0) begin
                                n_res_status = ST_PAGE0;
                            end else if (in_page_ext < PAGE_CAP) begin
                                n_state = S_FREE_RD;
                            end
                        end
                        KIND_FREE_RGN: begin
                            n_pstart = (in_page_ext < PAGE_CAP) ? in_page_ext : PAGE_CAP;
                            n_npg    = bytes_up[BYTES_W:PAGE_SHIFT];
                            n_state  = S_RGN_END;
                        end
                        KIND_RST_COUNT: begin
                            n_used = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_cnt != LAST_WORD) begin
                    n_word = (r_word == LAST_WORD) ? WORD_W'(1) : r_word + WORD_W'(1);
                    n_cnt  = r_cnt + WORD_W'(1);
                end
                if (r_rvalid) begin
                    if (i_rdata != FULL_WORD) begin
                        n_wr_addr  = r_raddr_q;
                        n_wr_data  = i_rdata | (DATA_W'(1) << zero_bit);
                        n_hint     = r_raddr_q;
                        n_res_addr = ADDR_W'(found_addr);
                        n_used     = (r_used < USED_MAX) ? r_used + COUNT_W'(1) : r_used;
                        n_state    = S_WRITE;
                    end else if (r_cnt == LAST_WORD) begin
                        n_res_status = ST_OOM;
                        n_state      = S_DONE;
                    end
                end
            end
            S_WRITE: begin
                n_state = S_DONE;
            end
            S_FREE_RD: begin
                n_state = S_FREE_WR;
            end
            S_FREE_WR: begin
                n_used  = (r_used != '0) ? r_used - COUNT_W'(1) : r_used;
                n_hint  = (r_wr_addr < r_hint) ? r_wr_addr : r_hint;
                n_state = S_DONE;
            end
            S_RGN_END: begin
                n_rg_end = (rg_sum < PAGE_CAP) ? rg_sum : PAGE_CAP;
                n_state  = S_RGN_CNT;
            end
            S_RGN_CNT: begin
                if (rg_k == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_used  = (used_ext > rg_k) ? COUNT_W'(used_ext - rg_k) : '0;
                    n_first = WORD_W'(r_pstart >> BIT_W);
                    n_last  = WORD_W'(rg_last_pg >> BIT_W);
                    n_lo    = r_pstart[BIT_W-1:0];
                    n_hi    = rg_last_pg[BIT_W-1:0];
                    n_word  = WORD_W'(r_pstart >> BIT_W);
                    n_iss   = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_iss) begin
                    n_word = r_word + WORD_W'(1);
                    if (r_word == r_last) begin
                        n_iss = 1'b0;
                    end
                end
                if (r_rvalid && r_raddr_q == r_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_used      <= USED_MAX;
            r_hint      <= WORD_W'(1);
            r_word      <= '0;
            r_cnt       <= '0;
            r_rvalid    <= 1'b0;
            r_iss       <= 1'b0;
            r_fill_init <= 1'b0;
            r_kind      <= KIND_INIT;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_hint      <= n_hint;
            r_word      <= n_word;
            r_cnt       <= n_cnt;
            r_rvalid    <= n_rvalid;
            r_iss       <= n_iss;
            r_fill_init <= n_fill_init;
            r_kind      <= n_kind;
        end
        r_raddr_q    <= n_raddr_q;
        r_wr_addr    <= n_wr_addr;
        r_wr_data    <= n_wr_data;
        r_fbit       <= n_fbit;
        r_pstart     <= n_pstart;
        r_npg        <= n_npg;
        r_rg_end     <= n_rg_end;
        r_first      <= n_first;
        r_last       <= n_last;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
    end

    assign o_ram_req      = ram_req;
    assign o_ready        = (r_state == S_IDLE);
    assign o_res_valid    = (r_state == S_DONE);
    assign o_page_address = r_res_addr;
    assign o_status       = r_res_status;
    assign o_pages_used   = r_used;

    `BPA_ASSERT_SAME(a_used_cap, 1'b1, r_used <= USED_MAX, "Used count exceeds the page total.")
    `BPA_ASSERT_SAME(a_no_rw_clash, ram_req.we && ram_req.re, ram_req.waddr != ram_req.raddr, "Read and write hit the same map word.")
    `BPA_ASSERT_NEXT(a_start_busy, i_start, r_state != S_IDLE, "Accepted item left the sequencer idle.")
    `BPA_ASSERT_SAME(a_alloc_addr, r_state == S_DONE && r_kind == KIND_ALLOC && r_res_status == ST_OK, r_res_addr != '0, "Successful allocation returned page zero.")

endmodule
